/* rtl/gpcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcb_pkg: shared types for the grace-period callback table
// Request and result layouts, internal command codes and state encoding.
// ----------------------------------------------------------------------------
package gpcb_pkg;

  typedef enum logic [2:0] {
    FN_INIT    = 3'd0,
    FN_LOCK    = 3'd1,
    FN_UNLOCK  = 3'd2,
    FN_ENQ     = 3'd3,
    FN_FREE    = 3'd4,
    FN_PROCESS = 3'd5,
    FN_QUERY   = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    RK_OK       = 2'd0,
    RK_REFUSE   = 2'd1,
    RK_DISPATCH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_LOCK,
    OP_UNLOCK,
    OP_ENQ,
    OP_PROC,
    OP_OK,
    OP_REFUSE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SW_RD,
    ST_SW_CHK,
    ST_SW_EMIT,
    ST_RETRY,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] callback_handle;
    logic [63:0] callback_arg;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] out_handle;
    logic [63:0] out_arg;
    logic        out_is_free;
    logic        last;
    logic [63:0] period_now;
    logic [15:0] nesting_now;
    logic [5:0]  pending_now;
    logic [31:0] periods_done;
    logic [31:0] queued_total;
    logic [31:0] invoked_total;
    logic [31:0] lock_total;
  } res_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] tok;
    logic [63:0] arg;
    logic        is_free;
  } cmd_t;

  localparam logic [15:0] NEST_MAX = 16'hFFFF;

endpackage

/* rtl/gpcb_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcb_fifo: two-entry queue
// Decouples the command and result sides; full and empty are decoded from a registered count.
// ----------------------------------------------------------------------------
module gpcb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule

/* rtl/gpcb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcb_front: request classifier
// Turns each request into an internal command for the execution engine.
// ----------------------------------------------------------------------------
module gpcb_front (
  input  logic          in_push,
  input  gpcb_pkg::req_t in_data,
  output logic          in_full,
  output logic          cmd_push,
  output gpcb_pkg::cmd_t cmd_data,
  input  logic          cmd_full
);
  import gpcb_pkg::*;

  assign in_full  = cmd_full;
  assign cmd_push = in_push;

  always_comb begin
    cmd_data.tok     = in_data.callback_handle;
    cmd_data.arg     = in_data.callback_arg;
    cmd_data.is_free = 1'b0;
    case (in_data.func)
      FN_INIT:    cmd_data.op = OP_INIT;
      FN_LOCK:    cmd_data.op = OP_LOCK;
      FN_UNLOCK:  cmd_data.op = OP_UNLOCK;
      FN_ENQ:     cmd_data.op = (in_data.callback_handle == 32'd0) ? OP_REFUSE : OP_ENQ;
      FN_FREE: begin
        // A free request is stored with a null token; freeing null is a no-op.
        cmd_data.tok     = 32'd0;
        cmd_data.is_free = 1'b1;
        cmd_data.op      = (in_data.callback_arg == 64'd0) ? OP_OK : OP_ENQ;
      end
      FN_PROCESS: cmd_data.op = OP_PROC;
      FN_QUERY:   cmd_data.op = OP_OK;
      default:    cmd_data.op = OP_REFUSE;
    endcase
  end
endmodule

/* rtl/gpcb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcb_back: execution engine
// Holds the slot table and counters, runs inserts and grace-period sweeps.
// ----------------------------------------------------------------------------
module gpcb_back #(
  parameter int SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  gpcb_pkg::cmd_t cmd_head,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output gpcb_pkg::res_t res_data
);
  import gpcb_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0]      tok_mem [SLOTS];
  logic [63:0]      arg_mem [SLOTS];
  logic [63:0]      tgt_mem [SLOTS];
  logic             free_mem [SLOTS];
  logic [31:0]      rd_tok_r;
  logic [63:0]      rd_arg_r, rd_tgt_r;
  logic             rd_free_r;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt, cur;
  kind_t            kind_r, kind_nxt;
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [63:0]      period_r, period_nxt;
  logic [15:0]      depth_r, depth_nxt;
  logic             ready_r, ready_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [31:0]      pstat_r, pstat_nxt, qstat_r, qstat_nxt;
  logic [31:0]      dstat_r, dstat_nxt, lstat_r, lstat_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, free_idx;
  logic             retry_r, retry_nxt, found, wr_en, last_idx;

  // Lowest free slot.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign cur      = (state_r == ST_IDLE) ? cmd_head : cmd_r;
  assign last_idx = (idx_r == IDX_W'(SLOTS - 1));

  always_comb begin
    res_data.result_kind   = kind_r;
    res_data.out_handle    = 32'd0;
    res_data.out_arg       = 64'd0;
    res_data.out_is_free   = 1'b0;
    res_data.last          = 1'b1;
    res_data.period_now    = period_r;
    res_data.nesting_now   = depth_r;
    res_data.pending_now   = cnt_r;
    res_data.periods_done  = pstat_r;
    res_data.queued_total  = qstat_r;
    res_data.invoked_total = dstat_r;
    res_data.lock_total    = lstat_r;
    if (state_r == ST_SW_EMIT) begin
      res_data.result_kind = RK_DISPATCH;
      res_data.out_handle  = rd_tok_r;
      res_data.out_arg     = rd_arg_r;
      res_data.out_is_free = rd_free_r;
      res_data.last        = 1'b0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    kind_nxt   = kind_r;
    busy_nxt   = busy_r;
    period_nxt = period_r;
    depth_nxt  = depth_r;
    ready_nxt  = ready_r;
    cnt_nxt    = cnt_r;
    pstat_nxt  = pstat_r;
    qstat_nxt  = qstat_r;
    dstat_nxt  = dstat_r;
    lstat_nxt  = lstat_r;
    idx_nxt    = idx_r;
    retry_nxt  = retry_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    wr_en      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_head;
          kind_nxt  = RK_OK;
          state_nxt = ST_CLOSE;
          case (cmd_head.op)
            OP_INIT: begin
              busy_nxt   = '0;
              period_nxt = 64'd1;
              depth_nxt  = 16'd0;
              ready_nxt  = 1'b1;
              cnt_nxt    = 6'd0;
              pstat_nxt  = 32'd0;
              qstat_nxt  = 32'd0;
              dstat_nxt  = 32'd0;
              lstat_nxt  = 32'd0;
            end
            OP_LOCK: begin
              if (depth_r != NEST_MAX) depth_nxt = depth_r + 16'd1;
              lstat_nxt = lstat_r + 32'd1;
            end
            OP_UNLOCK: begin
              if (depth_r != 16'd0) depth_nxt = depth_r - 16'd1;
            end
            OP_ENQ: begin
              if (!ready_r) begin
                kind_nxt = RK_REFUSE;
              end else if (found) begin
                wr_en              = 1'b1;
                busy_nxt[free_idx] = 1'b1;
                qstat_nxt          = qstat_r + 32'd1;
                cnt_nxt            = cnt_r + 6'd1;
              end else if (depth_r == 16'd0) begin
                // Table full: sweep once, then search again.
                period_nxt = period_r + 64'd1;
                pstat_nxt  = pstat_r + 32'd1;
                idx_nxt    = '0;
                retry_nxt  = 1'b1;
                state_nxt  = ST_SW_RD;
              end else begin
                kind_nxt = RK_REFUSE;
              end
            end
            OP_PROC: begin
              if (ready_r && depth_r == 16'd0) begin
                period_nxt = period_r + 64'd1;
                pstat_nxt  = pstat_r + 32'd1;
                idx_nxt    = '0;
                retry_nxt  = 1'b0;
                state_nxt  = ST_SW_RD;
              end else begin
                kind_nxt = RK_REFUSE;
              end
            end
            OP_OK:   kind_nxt = RK_OK;
            default: kind_nxt = RK_REFUSE;
          endcase
        end
      end
      ST_SW_RD: state_nxt = ST_SW_CHK;
      ST_SW_CHK: begin
        if (busy_r[idx_r] && period_r >= rd_tgt_r) begin
          busy_nxt[idx_r] = 1'b0;
          if (cnt_r != 6'd0) cnt_nxt = cnt_r - 6'd1;
          dstat_nxt = dstat_r + 32'd1;
          state_nxt = ST_SW_EMIT;
        end else if (!last_idx) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SW_RD;
        end else begin
          kind_nxt  = RK_OK;
          state_nxt = retry_r ? ST_RETRY : ST_CLOSE;
        end
      end
      ST_SW_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (!last_idx) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_SW_RD;
          end else begin
            kind_nxt  = RK_OK;
            state_nxt = retry_r ? ST_RETRY : ST_CLOSE;
          end
        end
      end
      ST_RETRY: begin
        state_nxt = ST_CLOSE;
        if (found) begin
          wr_en              = 1'b1;
          busy_nxt[free_idx] = 1'b1;
          qstat_nxt          = qstat_r + 32'd1;
          cnt_nxt            = cnt_r + 6'd1;
          kind_nxt           = RK_OK;
        end else begin
          kind_nxt = RK_REFUSE;
        end
      end
      ST_CLOSE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= '0;
      period_r <= 64'd0;
      depth_r  <= 16'd0;
      ready_r  <= 1'b0;
      cnt_r    <= 6'd0;
      pstat_r  <= 32'd0;
      qstat_r  <= 32'd0;
      dstat_r  <= 32'd0;
      lstat_r  <= 32'd0;
      retry_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      period_r <= period_nxt;
      depth_r  <= depth_nxt;
      ready_r  <= ready_nxt;
      cnt_r    <= cnt_nxt;
      pstat_r  <= pstat_nxt;
      qstat_r  <= qstat_nxt;
      dstat_r  <= dstat_nxt;
      lstat_r  <= lstat_nxt;
      retry_r  <= retry_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    kind_r <= kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_mem[free_idx]  <= cur.tok;
      arg_mem[free_idx]  <= cur.arg;
      tgt_mem[free_idx]  <= period_r + 64'd1;
      free_mem[free_idx] <= cur.is_free;
    end
  end

  always_ff @(posedge clk) begin
    rd_tok_r  <= tok_mem[idx_r];
    rd_arg_r  <= arg_mem[idx_r];
    rd_tgt_r  <= tgt_mem[idx_r];
    rd_free_r <= free_mem[idx_r];
  end
endmodule

/* rtl/grace_period_callback_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grace_period_callback_table: deferred callbacks released by grace periods
// Reader nesting, grace-period counter and a table of callback slots.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Moves
//  in        in_push, in_full, in_data     one request
//  out       out_pop, out_empty, out_data  one result per dispatch plus a closing one
//
// A simple request is executed in the engine, then its result is emitted.
// A process, or an enqueue that finds the table full, sweeps every slot through
// the table read port: a start step, then a read and a check per slot plus an emit
// per dispatch, a second insert attempt for a full-table enqueue, then a close.
// Reset is synchronous and empties both queues; the slot table needs no clearing.
// A stalled result side holds the engine; requests queue up to two deep meanwhile.
module grace_period_callback_table #(
  parameter int SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  gpcb_pkg::req_t in_data,
  output logic           in_full,
  input  logic           out_pop,
  output gpcb_pkg::res_t out_data,
  output logic           out_empty
);
  import gpcb_pkg::*;

  logic cmd_push, cmd_full, cmd_empty, cmd_pop, res_push, res_full;
  cmd_t cmd_in, cmd_head;
  res_t res_in;
  logic [$bits(cmd_t)-1:0] cmd_q;
  logic [$bits(res_t)-1:0] res_q;

  gpcb_front u_front (
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  gpcb_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_q),
    .empty (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_q);

  gpcb_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  gpcb_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  assign out_data = res_t'(res_q);
endmodule

/* rtl/gpcb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcb_checker: port-level checks for the grace-period callback table
// Watches the result channel for ordering and field consistency.
// ----------------------------------------------------------------------------
module gpcb_checker #(
  parameter int SLOTS = 32
) (
  input logic           clk,
  input logic           rst_n,
  input logic           out_pop,
  input gpcb_pkg::res_t out_data,
  input logic           out_empty
);
  import gpcb_pkg::*;

  // Nothing is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

  // Only dispatches precede the closing result.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.last) |-> (out_data.result_kind == RK_DISPATCH))
    else $error("non-closing result is not a dispatch");

  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.last) |->
      (out_data.out_handle == 32'd0 && out_data.out_arg == 64'd0 && !out_data.out_is_free))
    else $error("closing result carries slot data");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.pending_now <= 6'(SLOTS)))
    else $error("pending count exceeds slot count");
endmodule

bind grace_period_callback_table gpcb_checker #(.SLOTS(SLOTS)) u_gpcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_pop   (out_pop),
  .out_data  (out_data),
  .out_empty (out_empty)
);
